@@ design/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the sequential list store
// Entry width, list depth, request and status codes, and the control word
// broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  // Request codes
  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_FIRST  = 3'd4;
  localparam logic [2:0] REQ_LAST   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Control broadcast to every cell
  typedef struct packed {
    logic              append;  // write wdata into the cell at wr_idx
    logic              remove;  // cells at rm_pos and above take their upper neighbour
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rm_pos;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

@@ design/slc_cell.sv @@
// ----------------------------------------------------------------------------
// slc_cell: one storage cell of the list
// Holds one entry. Loads on append, takes the upper neighbour's entry when
// an entry at or below it is removed, and offers its entry on the read bus
// when its index is selected.
// ----------------------------------------------------------------------------
module slc_cell
  import slc_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,    // fixed position of this cell
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] nbr_i,    // entry of the cell above
  output logic [DATA_W-1:0] value_o,  // to the cell below
  output logic [DATA_W-1:0] rd_o      // zero unless selected
);

  logic [DATA_W-1:0] value_q, value_d;

  // Next entry: shift down on remove, load on append
  always_comb begin
    value_d = value_q;
    if (ctrl_i.remove && (idx_i >= ctrl_i.rm_pos)) begin
      value_d = nbr_i;
    end else if (ctrl_i.append && (idx_i == ctrl_i.wr_idx)) begin
      value_d = ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = (idx_i == ctrl_i.rd_idx) ? value_q : '0;

endmodule

@@ design/sequential_list_store_core.sv @@
// ----------------------------------------------------------------------------
// sequential_list_store_core: configurable-capacity ordered list of 32-bit values
// Append, read at index, remove with shift-down, clear, read first and read
// last, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i/in_ready_o, req_type_i,        | in
//          | new_value_i, position_i                   |
//  result  | out_valid_o/out_ready_i, read_value_o,    | out
//          | status_o, entry_count_o, is_full_o        |
//  config  | cfg_valid_i/cfg_ready_o, cfg_data_i       | in
//
// The row of cells shifts every entry above a removed index in the same
// cycle as the request is taken, and the result is registered, so the
// result beat is offered in the cycle after the request beat.
// A new request is taken while the result register is empty or being
// drained, so a stalled result holds off the request side only.
// Reset empties the list and sets the capacity to the full depth; stored
// entries are not cleared.
// ----------------------------------------------------------------------------
module sequential_list_store_core
  import slc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               req_type_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic [IDX_W-1:0]         position_i,
  // result
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     is_full_o,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_data_i
);

  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] rv_q, rv_d;
  logic [1:0]        st_q, st_d;
  logic              full_q, full_d;
  logic [CNT_W-1:0]  cap_eff;
  logic              in_fire;
  logic              is_full_now;
  logic              pos_ok;
  logic              not_empty;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DATA_W-1:0] cell_rd  [DEPTH];
  logic [DATA_W-1:0] rd_bus;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(DEPTH);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Clamp capacity into 1..DEPTH
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end
  end

  assign is_full_now = (count_q >= cap_eff);
  assign pos_ok      = ({1'b0, position_i} < count_q);
  assign not_empty   = (count_q != '0);

  // Cell control and next count
  always_comb begin
    ctrl.append = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.wr_idx = count_q[IDX_W-1:0];
    ctrl.rm_pos = position_i;
    ctrl.wdata  = new_value_i;
    ctrl.rd_idx = '0;
    count_d     = count_q;
    st_d        = ST_OK;
    unique case (req_type_i)
      REQ_APPEND: begin
        if (is_full_now) begin
          st_d = ST_FULL;
        end else begin
          ctrl.append = in_fire;
          count_d     = count_q + CNT_W'(1);
        end
      end
      REQ_READ: begin
        ctrl.rd_idx = position_i;
        if (!pos_ok) st_d = ST_RANGE;
      end
      REQ_REMOVE: begin
        if (!pos_ok) begin
          st_d = ST_RANGE;
        end else begin
          ctrl.remove = in_fire;
          count_d     = count_q - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      REQ_FIRST: begin
        if (!not_empty) st_d = ST_EMPTY;
      end
      REQ_LAST: begin
        ctrl.rd_idx = IDX_W'(count_q - CNT_W'(1));
        if (!not_empty) st_d = ST_EMPTY;
      end
      default: begin
      end
    endcase
  end

  // Row of cells, each shifting from the one above
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_top
      slc_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(g)),
        .ctrl_i  (ctrl),
        .nbr_i   (cell_val[g]),
        .value_o (cell_val[g]),
        .rd_o    (cell_rd[g])
      );
    end else begin : g_mid
      slc_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(g)),
        .ctrl_i  (ctrl),
        .nbr_i   (cell_val[g+1]),
        .value_o (cell_val[g]),
        .rd_o    (cell_rd[g])
      );
    end
  end

  // Read bus: only the selected cell drives non-zero
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Result payload
  always_comb begin
    rv_d = '0;
    if (st_d == ST_OK &&
        (req_type_i == REQ_READ || req_type_i == REQ_FIRST || req_type_i == REQ_LAST)) begin
      rv_d = rd_bus;
    end
    full_d = (count_d >= cap_eff);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rv_q   <= rv_d;
      st_q   <= st_d;
      full_q <= full_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rv_q;
  assign status_o      = st_q;
  assign entry_count_o = count_q;
  assign is_full_o     = full_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_type_i == REQ_CLEAR |=> out_valid_q && count_q == '0)
    else $error("clear did not empty the list");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_type_i == REQ_REMOVE && pos_ok |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not drop the count");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q == ST_EMPTY |-> count_q == '0 && rv_q == '0)
    else $error("empty status with entries or data");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sequential_list_store_core
// Requests go in over the request channel. Each accepted request updates a
// local image of the list and queues the result it should give. Results
// are compared field by field in arrival order. Directed cases cover the
// empty list, value extremes, out-of-range indices and capacity limits.
// Random phases then run under several capacities with idle bursts on both
// channels in all but the last phase, and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  import slc_pkg::*;

  // Request codes with no operation behind them
  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned LONG_HOLD_CYCLES = 60;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     full;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [2:0]               req_type_i;
  logic signed [DATA_W-1:0] new_value_i;
  logic [IDX_W-1:0]         position_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [1:0]               status_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic                     is_full_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         cfg_data_i;

  // Local image of the list and the capacity register
  logic signed [DATA_W-1:0] list_image [DEPTH];
  int unsigned              list_len;
  logic [CNT_W-1:0]         list_cap;

  list_result_t pending_list_results[$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles;
  bit           long_hold_req;
  bit           tx_idle_en;
  bit           rx_idle_en;

  sequential_list_store_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .new_value_i   (new_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the list image and return the result it gives
  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic signed [DATA_W-1:0] val,
                                                 input logic [IDX_W-1:0] pos);
    list_result_t r;
    int unsigned  lim;
    r        = '0;
    r.status = ST_OK;
    // zero acts as one, anything above the depth as the depth
    lim = (list_cap == 0) ? 1 : ((list_cap > DEPTH) ? DEPTH : list_cap);
    case (op)
      REQ_APPEND: begin
        if (list_len >= lim) begin
          r.status = ST_FULL;
        end else begin
          list_image[list_len] = val;
          list_len++;
        end
      end
      REQ_READ: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else                 r.value  = list_image[pos];
      end
      REQ_REMOVE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = pos; k + 1 < list_len; k++) list_image[k] = list_image[k + 1];
          list_len--;
        end
      end
      REQ_CLEAR: list_len = 0;
      REQ_FIRST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else               r.value  = list_image[0];
      end
      REQ_LAST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else               r.value  = list_image[list_len - 1];
      end
      default: ;
    endcase
    r.count = list_len[CNT_W-1:0];
    r.full  = (list_len >= lim);
    return r;
  endfunction

  // Offer one request beat, with an optional idle burst first
  task automatic send_list_op(input logic [2:0] op,
                              input logic signed [DATA_W-1:0] val,
                              input logic [IDX_W-1:0] pos);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type_i  = op;
    new_value_i = val;
    position_i  = pos;
    in_valid_i  = 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    pending_list_results.insert(pending_list_results.size(), apply_list_op(op, val, pos));
  endtask

  // Random request; positions mostly land inside the list
  task automatic send_random_op(input int unsigned append_pct);
    logic [2:0]               op;
    logic signed [DATA_W-1:0] val;
    logic [IDX_W-1:0]         pos;
    int unsigned              pick;
    if ($urandom_range(0, 99) < append_pct) begin
      op = REQ_APPEND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = REQ_READ;
      else if (pick < 60) op = REQ_REMOVE;
      else if (pick < 75) op = REQ_FIRST;
      else if (pick < 90) op = REQ_LAST;
      else if (pick < 95) op = REQ_CLEAR;
      else if (pick < 98) op = REQ_RSVD_A;
      else                op = REQ_RSVD_B;
    end
    case ($urandom_range(0, 15))
      0:       val = VAL_MIN;
      1:       val = VAL_MAX;
      2:       val = '0;
      3:       val = -1;
      default: val = $urandom;
    endcase
    if (list_len != 0 && $urandom_range(0, 3) != 0) begin
      pos = IDX_W'($urandom_range(0, list_len - 1));
    end else begin
      pos = IDX_W'($urandom_range(0, DEPTH - 1));
    end
    send_list_op(op, val, pos);
  endtask

  // Capacity write, only once every result is back
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    @(negedge clk);
    in_valid_i = 1'b0;
    while (pending_list_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_data_i  = cap;
    cfg_valid_i = 1'b1;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    list_cap = cap;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  // ---- directed tests ----

  task automatic test_empty_list();
    send_list_op(REQ_FIRST,  '0, '0);
    send_list_op(REQ_LAST,   '0, '0);
    send_list_op(REQ_READ,   '0, '0);
    send_list_op(REQ_REMOVE, '0, 6'd63);
    send_list_op(REQ_CLEAR,  '0, '0);
    send_list_op(REQ_RSVD_A, VAL_MAX, 6'd63);
    send_list_op(REQ_RSVD_B, VAL_MIN, '0);
  endtask

  task automatic test_value_extremes();
    send_list_op(REQ_APPEND, VAL_MIN, '0);
    send_list_op(REQ_APPEND, VAL_MAX, 6'd63);
    send_list_op(REQ_APPEND, '0, '0);
    send_list_op(REQ_APPEND, -1, '0);
    send_list_op(REQ_FIRST,  '0, '0);
    send_list_op(REQ_LAST,   '0, '0);
    send_list_op(REQ_READ,   '0, 6'd1);
    // index equal to the count is out of range
    send_list_op(REQ_READ,   '0, 6'd4);
    send_list_op(REQ_REMOVE, '0, 6'd1);
    send_list_op(REQ_READ,   '0, 6'd1);
  endtask

  task automatic test_capacity_limits();
    // zero acts as one, and the three held entries stay put
    write_capacity(7'd0);
    send_list_op(REQ_APPEND, 32'sd77, '0);
    send_list_op(REQ_READ,   '0, 6'd2);
    send_list_op(REQ_CLEAR,  '0, '0);
    send_list_op(REQ_APPEND, 32'sd5, '0);
    send_list_op(REQ_APPEND, 32'sd6, '0);
    // above the depth acts as the depth
    write_capacity(7'd127);
    send_list_op(REQ_APPEND, 32'sd8, '0);
  endtask

  // ---- random tests ----

  task automatic test_random_mix(input logic [CNT_W-1:0] cap,
                                 input int unsigned n_items,
                                 input int unsigned append_pct);
    write_capacity(cap);
    repeat (n_items) send_random_op(append_pct);
  endtask

  // Fill to the full depth, then work both ends of the list
  task automatic test_fill_to_depth();
    write_capacity(7'd127);
    send_list_op(REQ_CLEAR, '0, '0);
    repeat (DEPTH) send_list_op(REQ_APPEND, $urandom, '0);
    send_list_op(REQ_APPEND, VAL_MAX, '0);
    send_list_op(REQ_READ,   '0, 6'd63);
    send_list_op(REQ_REMOVE, '0, '0);
    send_list_op(REQ_LAST,   '0, '0);
    send_list_op(REQ_REMOVE, '0, 6'd62);
    send_list_op(REQ_READ,   '0, 6'd62);
    send_list_op(REQ_FIRST,  '0, '0);
  endtask

  // Result side held off while requests keep coming
  task automatic test_backpressure();
    write_capacity(7'd64);
    long_hold_req = 1'b1;
    repeat (25) send_random_op(50);
  endtask

  // ---- result sink: idle bursts plus the long hold ----
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_taken;
    stall_left  = 0;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk);
      // long hold starts once, when asked for
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(0, 8);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  function automatic void log_mismatch(input string what, input list_result_t want,
                                       input list_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $write("%0t %s: want value=%0d status=%0d count=%0d full=%0b, ",
             $time, what, want.value, want.status, want.count, want.full);
      $display("got value=%0d status=%0d count=%0d full=%0b",
               got.value, got.status, got.count, got.full);
    end
  endfunction

  // ---- result check on every result beat ----
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{read_value_o, status_o, entry_count_o, is_full_o};
      if (pending_list_results.size() == 0) begin
        log_mismatch("result with none pending", '0, got);
      end else begin
        want = pending_list_results.pop_front();
        if (got.value !== want.value || got.status !== want.status ||
            got.count !== want.count || got.full !== want.full)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---- watchdog: cycles without any beat ----
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // ---- main sequence ----
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_APPEND;
    new_value_i   = '0;
    position_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    long_hold_req = 1'b0;
    list_len      = 0;
    list_cap      = 7'd64;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (12) @(negedge clk);
    rst_ni = 1'b1;

    test_empty_list();
    test_value_extremes();
    test_capacity_limits();

    test_random_mix(7'd64, 400, 55);
    test_random_mix(7'd1, 150, 40);
    test_random_mix(CNT_W'($urandom_range(2, 63)), 300, 50);
    test_fill_to_depth();
    test_backpressure();
    test_random_mix(CNT_W'($urandom_range(1, 64)), 300, 35);
    // last stretch runs with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(7'd64, 600, 50);

    @(negedge clk);
    in_valid_i = 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_list_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/slc_pkg.sv
design/slc_cell.sv
design/sequential_list_store_core.sv
verif/tb_top.sv
